/* hw/rtl/fade_envelope_sequencer_unit_defines.svh */
// assertion macros for the fade envelope sequencer checker
// expects clk and rst in the scope where a macro is used
`ifndef FADE_ENVELOPE_SEQUENCER_UNIT_DEFINES_SVH
`define FADE_ENVELOPE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define FES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fes_pkg.sv */
// shared types, constants and the microcode rom of the fade envelope sequencer
// no dependencies
package fes_pkg;

  localparam int MAX_SCREENS_DEF = 16;
  localparam int TIME_BITS_DEF   = 16;

  localparam int CMD_W   = 2;
  localparam int DELTA_W = 16;
  localparam int SLOT_W  = 4;
  localparam int FADE_W  = 15;
  localparam int LEN_W   = 16;
  localparam int ALPHA_W = 8;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 5;

  // divider: numerator is x*255 with x <= fade, quotient always below 256
  localparam int NUM_W = FADE_W + ALPHA_W;
  localparam int DIV_W = FADE_W + ALPHA_W - 1;
  localparam int CNT_W = $clog2(ALPHA_W);

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = '1;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_SCREEN_COUNT = '0;
  localparam logic [COUNT_W-1:0] SCREEN_COUNT_RST = COUNT_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK, CMD_SKIP, CMD_RESTART, CMD_LOAD
  } cmd_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_ACCEPT, ACT_ADD, ACT_SKIP, ACT_CLEAR, ACT_WRITE,
    ACT_LD_RISE, ACT_LD_FALL, ACT_DIV, ACT_A_QUO, ACT_A_ZERO, ACT_A_FULL,
    ACT_ADVANCE, ACT_EMIT
  } action_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_ACCEPT, C_CMD_LOAD, C_CMD_RESTART, C_CMD_SKIP,
    C_DONE, C_FZERO, C_T_LE_F, C_NOT_TAIL, C_T_GE_D, C_DIV_MORE, C_NOT_TICK,
    C_OUT_FREE
  } cond_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    action_t action;
    cond_t   cond;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic no_accept;
    logic cmd_load;
    logic cmd_restart;
    logic cmd_skip;
    logic done;
    logic fzero;
    logic t_le_f;
    logic not_tail;
    logic t_ge_d;
    logic div_more;
    logic not_tick;
    logic out_free;
  } flags_t;

  localparam step_t S_IDLE      = STEP_W'(0);
  localparam step_t S_DISP_LOAD = STEP_W'(1);
  localparam step_t S_DISP_RST  = STEP_W'(2);
  localparam step_t S_DISP_DONE = STEP_W'(3);
  localparam step_t S_DISP_SKIP = STEP_W'(4);
  localparam step_t S_TICK      = STEP_W'(5);
  localparam step_t S_SKIP      = STEP_W'(6);
  localparam step_t S_RESTART   = STEP_W'(7);
  localparam step_t S_RST_WAIT  = STEP_W'(8);
  localparam step_t S_LOAD      = STEP_W'(9);
  localparam step_t S_LOAD_WAIT = STEP_W'(10);
  localparam step_t S_ENV       = STEP_W'(11);
  localparam step_t S_ENV_FZERO = STEP_W'(12);
  localparam step_t S_ENV_RISE  = STEP_W'(13);
  localparam step_t S_ENV_FLAT  = STEP_W'(14);
  localparam step_t S_ENV_PAST  = STEP_W'(15);
  localparam step_t S_FALL      = STEP_W'(16);
  localparam step_t S_RISE      = STEP_W'(17);
  localparam step_t S_DIV       = STEP_W'(18);
  localparam step_t S_QUO       = STEP_W'(19);
  localparam step_t S_ZERO      = STEP_W'(20);
  localparam step_t S_FULL      = STEP_W'(21);
  localparam step_t S_POST      = STEP_W'(22);
  localparam step_t S_ADVANCE   = STEP_W'(23);
  localparam step_t S_EMIT      = STEP_W'(24);
  localparam step_t S_EMIT_WAIT = STEP_W'(25);

  // control store: action, jump condition, jump target (else fall through)
  function automatic uword_t fes_ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:      w = '{ACT_ACCEPT,  C_NO_ACCEPT,   S_IDLE};
      S_DISP_LOAD: w = '{ACT_NONE,    C_CMD_LOAD,    S_LOAD};
      S_DISP_RST:  w = '{ACT_NONE,    C_CMD_RESTART, S_RESTART};
      S_DISP_DONE: w = '{ACT_NONE,    C_DONE,        S_ZERO};
      S_DISP_SKIP: w = '{ACT_NONE,    C_CMD_SKIP,    S_SKIP};
      S_TICK:      w = '{ACT_ADD,     C_ALWAYS,      S_ENV};
      S_SKIP:      w = '{ACT_SKIP,    C_ALWAYS,      S_ENV};
      S_RESTART:   w = '{ACT_CLEAR,   C_NEVER,       S_IDLE};
      S_RST_WAIT:  w = '{ACT_NONE,    C_ALWAYS,      S_ENV};
      S_LOAD:      w = '{ACT_WRITE,   C_NEVER,       S_IDLE};
      S_LOAD_WAIT: w = '{ACT_NONE,    C_NEVER,       S_IDLE};
      S_ENV:       w = '{ACT_NONE,    C_DONE,        S_ZERO};
      S_ENV_FZERO: w = '{ACT_NONE,    C_FZERO,       S_FULL};
      S_ENV_RISE:  w = '{ACT_NONE,    C_T_LE_F,      S_RISE};
      S_ENV_FLAT:  w = '{ACT_NONE,    C_NOT_TAIL,    S_FULL};
      S_ENV_PAST:  w = '{ACT_NONE,    C_T_GE_D,      S_ZERO};
      S_FALL:      w = '{ACT_LD_FALL, C_ALWAYS,      S_DIV};
      S_RISE:      w = '{ACT_LD_RISE, C_NEVER,       S_IDLE};
      S_DIV:       w = '{ACT_DIV,     C_DIV_MORE,    S_DIV};
      S_QUO:       w = '{ACT_A_QUO,   C_ALWAYS,      S_POST};
      S_ZERO:      w = '{ACT_A_ZERO,  C_ALWAYS,      S_POST};
      S_FULL:      w = '{ACT_A_FULL,  C_NEVER,       S_IDLE};
      S_POST:      w = '{ACT_NONE,    C_NOT_TICK,    S_EMIT};
      S_ADVANCE:   w = '{ACT_ADVANCE, C_NEVER,       S_IDLE};
      S_EMIT:      w = '{ACT_EMIT,    C_OUT_FREE,    S_IDLE};
      S_EMIT_WAIT: w = '{ACT_NONE,    C_ALWAYS,      S_EMIT};
      default:     w = '{ACT_NONE,    C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/fes_if.sv */
// valid/ready channel interfaces for commands and results
// depends on fes_pkg
interface fes_in_if import fes_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [DELTA_W-1:0]   delta_ticks;
  logic [SLOT_W-1:0]    entry_slot;
  logic [FADE_W-1:0]    entry_fade;
  logic [LEN_W-1:0]     entry_length;

  modport source (output valid, cmd, delta_ticks, entry_slot, entry_fade, entry_length,
                  input ready);
  modport sink (input valid, cmd, delta_ticks, entry_slot, entry_fade, entry_length,
                output ready);
endinterface

interface fes_out_if import fes_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ALPHA_W-1:0]   alpha;
  logic [INDEX_W-1:0]   screen_index;
  logic                 all_done;

  modport source (output valid, alpha, screen_index, all_done, input ready);
  modport sink (input valid, alpha, screen_index, all_done, output ready);
endinterface

/* hw/rtl/fes_regs.sv */
// apb configuration register file: screen_count
// depends on fes_pkg
module fes_regs import fes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [COUNT_W-1:0]    screen_count
);

  logic [APB_ADDR_W-REG_IDX_LSB-1:0] reg_sel;
  logic                              wr;

  assign reg_sel = paddr[APB_ADDR_W-1:REG_IDX_LSB];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_count <= SCREEN_COUNT_RST;
    end else if (wr && reg_sel == REG_SCREEN_COUNT) begin
      screen_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_COUNT: prdata = APB_DATA_W'(screen_count);
      default:          prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/fes_sequencer.sv */
// microcode sequencer: step counter, control store and conditional jumps
// depends on fes_pkg
module fes_sequencer import fes_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output uword_t uw
);

  step_t step;
  step_t step_next;
  logic  take;

  always_comb begin
    uw = fes_ucode(step);
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_ACCEPT:   take = flags.no_accept;
      C_CMD_LOAD:    take = flags.cmd_load;
      C_CMD_RESTART: take = flags.cmd_restart;
      C_CMD_SKIP:    take = flags.cmd_skip;
      C_DONE:        take = flags.done;
      C_FZERO:       take = flags.fzero;
      C_T_LE_F:      take = flags.t_le_f;
      C_NOT_TAIL:    take = flags.not_tail;
      C_T_GE_D:      take = flags.t_ge_d;
      C_DIV_MORE:    take = flags.div_more;
      C_NOT_TICK:    take = flags.not_tick;
      C_OUT_FREE:    take = flags.out_free;
      default:       take = 1'b0;
    endcase
    step_next = take ? uw.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* hw/rtl/fes_datapath.sv */
// datapath: screen tables, elapsed time, screen index, serial divider, result register
// depends on fes_pkg and the channel interfaces; driven by fes_sequencer
module fes_datapath import fes_pkg::*; #(
  parameter int MAX_SCREENS = MAX_SCREENS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  uword_t             uw,
  output flags_t             flags,
  input  logic [COUNT_W-1:0] screen_count,
  fes_in_if.sink             command,
  fes_out_if.source          results
);

  localparam int EW = TIME_BITS + 1;
  localparam int SW = ((EW > DELTA_W) ? EW : DELTA_W) + 1;
  localparam int CW = ((EW > LEN_W) ? EW : LEN_W) + 1;
  localparam int IW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

  logic [FADE_W-1:0] fade_mem [MAX_SCREENS];
  logic [LEN_W-1:0]  len_mem  [MAX_SCREENS];

  cmd_t               cmd_q;
  logic [DELTA_W-1:0] delta_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FADE_W-1:0]  fade_q;
  logic [LEN_W-1:0]   len_q;

  logic [EW-1:0]      elapsed;
  logic [INDEX_W-1:0] cur;
  logic [FADE_W-1:0]  rd_fade;
  logic [LEN_W-1:0]   rd_len;

  logic [NUM_W-1:0]   rem;
  logic [DIV_W-1:0]   dvs;
  logic [ALPHA_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic [ALPHA_W-1:0] alpha_q;

  logic               out_valid;
  logic [ALPHA_W-1:0] out_alpha;
  logic [INDEX_W-1:0] out_index;
  logic               out_done;

  logic [COUNT_W-1:0] active;
  logic               done;
  logic [SW-1:0]      sum_w;
  logic               add_sat;
  logic [CW-1:0]      t_c, f_c, d_c;
  logic               t_le_f, tail, t_ge_d, skip_ok;
  logic [EW-1:0]      skip_val;
  logic [FADE_W-1:0]  mul_src;
  logic [NUM_W-1:0]   mul;
  logic               div_ge;
  logic               out_free;
  logic               slot_ok;
  logic [IW-1:0]      rd_addr, wr_addr;

  always_comb begin
    active   = (int'(screen_count) < MAX_SCREENS) ? screen_count : COUNT_W'(MAX_SCREENS);
    done     = cur >= INDEX_W'(active);
    sum_w    = SW'(elapsed) + SW'(delta_q);
    add_sat  = |sum_w[SW-1:EW];
    t_c      = CW'(elapsed);
    f_c      = CW'(rd_fade);
    d_c      = CW'(rd_len);
    t_le_f   = t_c <= f_c;
    tail     = (t_c + f_c) >= d_c;
    t_ge_d   = t_c >= d_c;
    skip_ok  = !t_le_f && !tail;
    skip_val = EW'(d_c - f_c);
    // rising edge uses elapsed, falling edge the time left; both stay within the fade
    mul_src  = (uw.action == ACT_LD_FALL) ? FADE_W'(d_c - t_c) : FADE_W'(elapsed);
    mul      = (NUM_W'(mul_src) << ALPHA_W) - NUM_W'(mul_src);
    div_ge   = rem >= NUM_W'(dvs);
    out_free = !out_valid || results.ready;
    slot_ok  = int'(slot_q) < MAX_SCREENS;
    rd_addr  = IW'(cur);
    wr_addr  = IW'(slot_q);
  end

  assign command.ready        = (uw.action == ACT_ACCEPT);
  assign results.valid        = out_valid;
  assign results.alpha        = out_alpha;
  assign results.screen_index = out_index;
  assign results.all_done     = out_done;

  always_comb begin
    flags.no_accept   = !command.valid;
    flags.cmd_load    = cmd_q == CMD_LOAD;
    flags.cmd_restart = cmd_q == CMD_RESTART;
    flags.cmd_skip    = cmd_q == CMD_SKIP;
    flags.done        = done;
    flags.fzero       = rd_fade == '0;
    flags.t_le_f      = t_le_f;
    flags.not_tail    = !tail;
    flags.t_ge_d      = t_ge_d;
    flags.div_more    = cnt != '0;
    flags.not_tick    = cmd_q != CMD_TICK;
    flags.out_free    = out_free;
  end

  // screen tables, registered read at the current screen
  always_ff @(posedge clk) begin
    if (uw.action == ACT_WRITE && slot_ok) begin
      fade_mem[wr_addr] <= fade_q;
      len_mem[wr_addr]  <= len_q;
    end
    rd_fade <= fade_mem[rd_addr];
    rd_len  <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (uw.action == ACT_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (uw.action)
        ACT_ADD:     elapsed <= add_sat ? '1 : sum_w[EW-1:0];
        ACT_SKIP:    if (skip_ok) elapsed <= skip_val;
        ACT_CLEAR: begin
          elapsed <= '0;
          cur     <= '0;
        end
        ACT_LD_RISE, ACT_LD_FALL: cnt <= '1;
        ACT_DIV:     cnt <= cnt - CNT_W'(1);
        ACT_ADVANCE: if (!done && t_ge_d) begin
          cur     <= cur + INDEX_W'(1);
          elapsed <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.action)
      ACT_ACCEPT: if (command.valid) begin
        cmd_q   <= cmd_t'(command.cmd);
        delta_q <= command.delta_ticks;
        slot_q  <= command.entry_slot;
        fade_q  <= command.entry_fade;
        len_q   <= command.entry_length;
      end
      ACT_LD_RISE, ACT_LD_FALL: begin
        rem <= mul;
        dvs <= DIV_W'(rd_fade) << (ALPHA_W - 1);
        quo <= '0;
      end
      // restoring division, one quotient bit a step, msb first
      ACT_DIV: begin
        if (div_ge) rem <= rem - NUM_W'(dvs);
        quo <= {quo[ALPHA_W-2:0], div_ge};
        dvs <= dvs >> 1;
      end
      ACT_A_QUO:  alpha_q <= quo;
      ACT_A_ZERO: alpha_q <= '0;
      ACT_A_FULL: alpha_q <= ALPHA_FULL;
      ACT_EMIT: if (out_free) begin
        out_alpha <= alpha_q;
        out_index <= cur;
        out_done  <= done;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/fade_envelope_sequencer_unit.sv */
// top level of the fade envelope sequencer: config registers, microcode sequencer, datapath
// depends on fes_pkg, fes_if, fes_regs, fes_sequencer, fes_datapath
//
//  channel   | kind        | payload
//  ----------+-------------+-----------------------------------------------------
//  command   | valid/ready | cmd, delta_ticks, entry_slot, entry_fade, entry_length
//  results   | valid/ready | alpha, screen_index, all_done
//  apb       | write/read  | screen_count at byte address 0
//
// one command in flight at a time; from one accept to the next the command runs through
// microcode steps, among them the 8-step restoring divider for fade alpha
// the next command is accepted while a result still waits in the output register
// a stalled result holds in that register and the microcode waits at its emit step
// reset (rst, synchronous) clears elapsed time, screen index and control; tables are
// undefined until loaded
module fade_envelope_sequencer_unit import fes_pkg::*; #(
  parameter int MAX_SCREENS = MAX_SCREENS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  fes_in_if.sink                command,
  fes_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [COUNT_W-1:0] screen_count;
  uword_t             uw;
  flags_t             flags;

  fes_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .screen_count (screen_count)
  );

  fes_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  fes_datapath #(
    .MAX_SCREENS (MAX_SCREENS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .uw           (uw),
    .flags        (flags),
    .screen_count (screen_count),
    .command      (command),
    .results      (results)
  );

endmodule

/* hw/rtl/fes_checker.sv */
// port-level checks for the fade envelope sequencer, bound to the top level
// depends on fes_pkg and fade_envelope_sequencer_unit_defines.svh
`include "fade_envelope_sequencer_unit_defines.svh"

module fes_checker import fes_pkg::*; #(
  parameter int MAX_SCREENS = MAX_SCREENS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [ALPHA_W-1:0] alpha,
  input logic [INDEX_W-1:0] screen_index,
  input logic               all_done,
  input logic               pready
);

  // one command at a time: no back-to-back acceptance
  `FES_ASSERT_NXT(a_single_item, cmd_valid && cmd_ready, !cmd_ready, "command accepted twice in a row")

  // a waiting result holds
  `FES_ASSERT_NXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(alpha) && $stable(screen_index) && $stable(all_done), "stalled result changed")

  // a screen still running lies inside the table
  `FES_ASSERT_IMP(a_index_range, res_valid && !all_done, int'(screen_index) < MAX_SCREENS, "screen index beyond table while not done")

  `FES_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")

endmodule

bind fade_envelope_sequencer_unit fes_checker #(
  .MAX_SCREENS (MAX_SCREENS)
) u_fes_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (command.valid),
  .cmd_ready    (command.ready),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .alpha        (results.alpha),
  .screen_index (results.screen_index),
  .all_done     (results.all_done),
  .pready       (pready)
);
